// ===== rtl/cmr_pkg.sv =====
// Shared constants, mu lookup functions and saturation for the spline sampler.
`default_nettype none

package cmr_pkg;

    localparam int CoordW   = 32;             // Q16.16 coordinate width
    localparam int DiffW    = CoordW + 1;     // difference of two coordinates
    localparam int MuW      = 17;             // Q0.16 mu power, 1.0 included
    localparam int CoefW    = 38;             // doubled Hermite coefficient
    localparam int ProdW    = CoefW + MuW + 1;
    localparam int AccW     = ProdW + 2;
    localparam int SumW     = 42;             // shifted term plus base point
    localparam int KW       = 4;
    localparam int OutDataW = 72;             // x, y, k padded to whole bytes

    localparam logic [KW-1:0] LastK = 4'd10;  // mu = 1.0

    function automatic logic [MuW-1:0] mu1_lut(input logic [KW-1:0] k);
        case (k)
            4'd0:    mu1_lut = 17'd0;
            4'd1:    mu1_lut = 17'd6554;
            4'd2:    mu1_lut = 17'd13107;
            4'd3:    mu1_lut = 17'd19661;
            4'd4:    mu1_lut = 17'd26214;
            4'd5:    mu1_lut = 17'd32768;
            4'd6:    mu1_lut = 17'd39322;
            4'd7:    mu1_lut = 17'd45875;
            4'd8:    mu1_lut = 17'd52429;
            4'd9:    mu1_lut = 17'd58982;
            4'd10:   mu1_lut = 17'd65536;
            default: mu1_lut = 17'd0;
        endcase
    endfunction

    function automatic logic [MuW-1:0] mu2_lut(input logic [KW-1:0] k);
        case (k)
            4'd0:    mu2_lut = 17'd0;
            4'd1:    mu2_lut = 17'd655;
            4'd2:    mu2_lut = 17'd2621;
            4'd3:    mu2_lut = 17'd5898;
            4'd4:    mu2_lut = 17'd10486;
            4'd5:    mu2_lut = 17'd16384;
            4'd6:    mu2_lut = 17'd23593;
            4'd7:    mu2_lut = 17'd32113;
            4'd8:    mu2_lut = 17'd41943;
            4'd9:    mu2_lut = 17'd53084;
            4'd10:   mu2_lut = 17'd65536;
            default: mu2_lut = 17'd0;
        endcase
    endfunction

    function automatic logic [MuW-1:0] mu3_lut(input logic [KW-1:0] k);
        case (k)
            4'd0:    mu3_lut = 17'd0;
            4'd1:    mu3_lut = 17'd66;
            4'd2:    mu3_lut = 17'd524;
            4'd3:    mu3_lut = 17'd1769;
            4'd4:    mu3_lut = 17'd4194;
            4'd5:    mu3_lut = 17'd8192;
            4'd6:    mu3_lut = 17'd14156;
            4'd7:    mu3_lut = 17'd22479;
            4'd8:    mu3_lut = 17'd33554;
            4'd9:    mu3_lut = 17'd47776;
            4'd10:   mu3_lut = 17'd65536;
            default: mu3_lut = 17'd0;
        endcase
    endfunction

    // Clamp a wide signed sum to the signed 32-bit range.
    function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [SumW-1:0] v);
        if ((&v[SumW-1:CoordW-1]) || !(|v[SumW-1:CoordW-1])) begin
            sat_coord = v[CoordW-1:0];
        end else if (v[SumW-1]) begin
            sat_coord = {1'b1, {(CoordW-1){1'b0}}};
        end else begin
            sat_coord = {1'b0, {(CoordW-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cmr_mul.sv =====
// Shared signed-by-unsigned multiplier with a registered product.
`default_nettype none

module cmr_mul (
    input  wire logic                               i_clk,
    input  wire logic signed [cmr_pkg::CoefW-1:0]   i_a,
    input  wire logic        [cmr_pkg::MuW-1:0]     i_b,
    output logic signed      [cmr_pkg::ProdW-1:0]   o_p
);
    import cmr_pkg::*;

    logic signed [ProdW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= ProdW'($signed(i_a) * $signed({1'b0, i_b}));
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ===== rtl/catmull_rom_path_sampler.sv =====
// Top level: waypoint window, sample sequencer and output register of the path sampler.
`default_nettype none
// Usage:
// Waypoints enter on the s_axis channel: tdata holds x in bits 31:0 and y in bits
// 63:32 (both signed Q16.16), tlast marks the final waypoint of a path. Samples leave
// on the m_axis channel, one beat each: tdata holds x, y and the sample index k
// (mu = k/10), tlast flags the final sample caused by one waypoint.
// A waypoint opens zero, one or two segments of 11 samples each. The sequencer feeds
// one shared multiplier four products per sample (x slope, then three powers of mu);
// each segment opens with setup steps that register the point differences and then
// the coefficients. An input beat that opens no segment only updates the waypoint
// window. s_axis_tready is high only while the block waits for a waypoint, so a new
// waypoint is taken only once all samples of the last one have been produced.
// When the receiver stalls, the finished sample stays in the output register and the
// sequencer holds until that beat is taken.
// Reset empties the waypoint window and the output register; the block is ready in
// the first cycle after reset.
module catmull_rom_path_sampler (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [63:0]          s_axis_tdata,   // in_x [31:0], in_y [63:32]
    input  wire logic                 s_axis_tlast,   // in_last
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [cmr_pkg::OutDataW-1:0] m_axis_tdata, // out_x [31:0], out_y [63:32],
                                                       // sample_index [67:64], zeros above
    output logic                      m_axis_tlast    // run_last
);
    import cmr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_COEF, S_MX, S_M1, S_M2, S_M3, S_ACC, S_OUT, S_WIN
    } t_state;

    t_state r_state;

    // Waypoint window, oldest at index 0.
    logic signed [CoordW-1:0] r_wx [3];
    logic signed [CoordW-1:0] r_wy [3];
    logic        [1:0]        r_cnt;

    logic signed [CoordW-1:0] r_in_x, r_in_y;
    logic                     r_in_last;
    logic                     r_two;     // item opens two segments
    logic                     r_seg;     // segment being sampled
    logic        [KW-1:0]     r_k;

    logic signed [DiffW-1:0]  r_d1, r_d2, r_e, r_dx;
    logic signed [CoordW-1:0] r_p1, r_x1;
    logic signed [CoefW-1:0]  r_c1, r_c2, r_c3;
    logic signed [AccW-1:0]   r_acc;
    logic signed [SumW-1:0]   r_xs;

    logic                     r_m_valid, r_m_last;
    logic signed [CoordW-1:0] r_m_x, r_m_y;
    logic        [KW-1:0]     r_m_k;

    logic signed [CoordW-1:0] sel_p0, sel_p1, sel_p2, sel_p3, sel_x1, sel_x2;
    logic                     tail;
    logic signed [CoefW-1:0]  mul_a;
    logic        [MuW-1:0]    mul_b;
    logic signed [ProdW-1:0]  prod;
    logic signed [AccW-1:0]   prod_ext;
    logic signed [CoefW-1:0]  e_ext, d1_ext, d2_ext;
    logic signed [SumW-1:0]   n_y_sum;
    logic                     out_free;
    logic                     seg_done, item_done;
    logic        [1:0]        n_segs;

    cmr_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // The closing segment of a path runs from the newest stored point to the input.
    always_comb begin
        tail = r_seg | (r_in_last & (r_cnt == 2'd1));
        if (tail) begin
            sel_p0 = (r_cnt == 2'd1) ? r_in_y : r_wy[1];
            sel_p1 = r_wy[2];
            sel_p2 = r_in_y;
            sel_p3 = r_wy[2];
            sel_x1 = r_wx[2];
            sel_x2 = r_in_x;
        end else begin
            sel_p0 = (r_cnt == 2'd2) ? r_wy[2] : r_wy[0];
            sel_p1 = r_wy[1];
            sel_p2 = r_wy[2];
            sel_p3 = r_in_y;
            sel_x1 = r_wx[1];
            sel_x2 = r_wx[2];
        end
    end

    always_comb begin
        case (r_state)
            S_MX: begin
                mul_a = {{(CoefW-DiffW){r_dx[DiffW-1]}}, r_dx};
                mul_b = mu1_lut(r_k);
            end
            S_M1: begin
                mul_a = r_c1;
                mul_b = mu1_lut(r_k);
            end
            S_M2: begin
                mul_a = r_c2;
                mul_b = mu2_lut(r_k);
            end
            S_M3: begin
                mul_a = r_c3;
                mul_b = mu3_lut(r_k);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        prod_ext = {{(AccW-ProdW){prod[ProdW-1]}}, prod};
        e_ext    = {{(CoefW-DiffW){r_e[DiffW-1]}}, r_e};
        d1_ext   = {{(CoefW-DiffW){r_d1[DiffW-1]}}, r_d1};
        d2_ext   = {{(CoefW-DiffW){r_d2[DiffW-1]}}, r_d2};
        n_y_sum  = {{(SumW-CoordW){r_p1[CoordW-1]}}, r_p1} + SumW'(r_acc >>> 17);
        out_free = !r_m_valid || m_axis_tready;
        seg_done  = (r_k == LastK);
        item_done = seg_done && (r_seg == r_two);
        if (!s_axis_tlast) begin
            n_segs = (r_cnt >= 2'd2) ? 2'd1 : 2'd0;
        end else begin
            n_segs = (r_cnt >= 2'd2) ? 2'd2 : {1'b0, (r_cnt == 2'd1)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= 2'd0;
            r_m_valid <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_in_x    <= s_axis_tdata[31:0];
                        r_in_y    <= s_axis_tdata[63:32];
                        r_in_last <= s_axis_tlast;
                        r_two     <= (n_segs == 2'd2);
                        r_seg     <= 1'b0;
                        r_k       <= '0;
                        r_state   <= (n_segs == 2'd0) ? S_WIN : S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_d1    <= {sel_p2[CoordW-1], sel_p2} - {sel_p0[CoordW-1], sel_p0};
                    r_d2    <= {sel_p3[CoordW-1], sel_p3} - {sel_p1[CoordW-1], sel_p1};
                    r_e     <= {sel_p2[CoordW-1], sel_p2} - {sel_p1[CoordW-1], sel_p1};
                    r_dx    <= {sel_x2[CoordW-1], sel_x2} - {sel_x1[CoordW-1], sel_x1};
                    r_p1    <= sel_p1;
                    r_x1    <= sel_x1;
                    r_state <= S_COEF;
                end
                S_COEF: begin
                    r_c1    <= d1_ext;
                    r_c2    <= (e_ext <<< 2) + (e_ext <<< 1) - (d1_ext <<< 1) - d2_ext;
                    r_c3    <= d1_ext + d2_ext - (e_ext <<< 2);
                    r_state <= S_MX;
                end
                S_MX: begin
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_xs    <= {{(SumW-CoordW){r_x1[CoordW-1]}}, r_x1} + SumW'(prod >>> 16);
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_acc   <= prod_ext;
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_acc   <= r_acc + prod_ext;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc   <= r_acc + prod_ext;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_m_x     <= sat_coord(r_xs);
                        r_m_y     <= sat_coord(n_y_sum);
                        r_m_k     <= r_k;
                        r_m_last  <= item_done;
                        if (item_done) begin
                            r_state <= S_WIN;
                        end else if (seg_done) begin
                            r_seg   <= 1'b1;
                            r_k     <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_k     <= r_k + 4'd1;
                            r_state <= S_MX;
                        end
                    end
                end
                S_WIN: begin
                    if (r_in_last) begin
                        r_cnt <= 2'd0;
                    end else begin
                        r_wx[0] <= r_wx[1];
                        r_wx[1] <= r_wx[2];
                        r_wx[2] <= r_in_x;
                        r_wy[0] <= r_wy[1];
                        r_wy[1] <= r_wy[2];
                        r_wy[2] <= r_in_y;
                        if (r_cnt != 2'd3) begin
                            r_cnt <= r_cnt + 2'd1;
                        end
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(OutDataW-2*CoordW-KW){1'b0}}, r_m_k, r_m_y, r_m_x};
    assign m_axis_tlast  = r_m_last;

endmodule

`default_nettype wire
